// ----- hdl/tmre_pkg.sv -----
// Shared types and constants for the trimmed median rate estimator.
`timescale 1ns / 1ps

package tmre_pkg;

   localparam int US_W     = 32;
   localparam int RATE_W   = 20;
   localparam int COUNT_W  = 10;
   localparam int STEP_W   = $clog2(RATE_W);

   localparam logic [RATE_W-1:0] US_PER_SECOND = RATE_W'(1000000);
   localparam logic [RATE_W-1:0] RATE_MAX      = {RATE_W{1'b1}};

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_SHIFT_RD,
      ST_SHIFT_CMP,
      ST_PLACE,
      ST_MED_RD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hdl/tmre_req_if.sv -----
// Input channel carrying one measured upload time per transfer.
`timescale 1ns / 1ps

interface tmre_req_if;
   logic                        valid;
   logic                        ready;
   logic [tmre_pkg::US_W-1:0]   elapsed_us;

   modport source (output valid, output elapsed_us, input ready);
   modport sink   (input valid, input elapsed_us, output ready);
endinterface

// ----- hdl/tmre_rsp_if.sv -----
// Result channel carrying the median rate and history count per transfer.
`timescale 1ns / 1ps

interface tmre_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmre_pkg::RATE_W-1:0]   median_rate;
   logic [tmre_pkg::COUNT_W-1:0]  history_count;

   modport source (output valid, output median_rate, output history_count, input ready);
   modport sink   (input valid, input median_rate, input history_count, output ready);
endinterface

// ----- hdl/tmre_div.sv -----
// Iterative restoring divider that turns an upload time into a rate, one bit per cycle.
`timescale 1ns / 1ps

module tmre_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmre_pkg::US_W-1:0]     divisor,
   output tmre_pkg::div_status_type      status,
   output logic [tmre_pkg::RATE_W-1:0]   quotient
);

   logic                              busy_ff,    busy_in;
   logic                              done_ff,    done_in;
   logic [tmre_pkg::STEP_W-1:0]       step_ff,    step_in;
   logic [tmre_pkg::RATE_W-1:0]       rem_ff,     rem_in;
   logic [tmre_pkg::RATE_W-1:0]       quo_ff,     quo_in;
   logic [tmre_pkg::US_W-1:0]         divisor_ff, divisor_in;

   logic [tmre_pkg::RATE_W:0]         trial;
   logic [tmre_pkg::US_W-1:0]         trial_ext;
   logic [tmre_pkg::US_W-1:0]         diff;
   logic                              fits;

   always_comb begin
      trial     = {rem_ff, tmre_pkg::US_PER_SECOND[step_ff]};
      trial_ext = tmre_pkg::US_W'(trial);
      fits      = trial_ext >= divisor_ff;
      diff      = trial_ext - divisor_ff;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = tmre_pkg::STEP_W'(tmre_pkg::RATE_W - 1);
         rem_in     = '0;
         quo_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tmre_pkg::RATE_W-1:0] : trial[tmre_pkg::RATE_W-1:0];
         quo_in = {quo_ff[tmre_pkg::RATE_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - tmre_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = (divisor_ff == '0) ? tmre_pkg::RATE_MAX : quo_ff;

endmodule

// ----- hdl/tmre_store.sv -----
// Single-port-write, registered-read memory that holds the rate history.
`timescale 1ns / 1ps

module tmre_store #(
   parameter int DEPTH = 1000
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [tmre_pkg::RATE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [tmre_pkg::RATE_W-1:0]   rd_data
);

   logic [tmre_pkg::RATE_W-1:0] mem [DEPTH];
   logic [tmre_pkg::RATE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/trimmed_median_rate_estimator.sv -----
// Top level: sequencer that converts times to rates and keeps a sorted, trimmed history.
// The insertion shift loop, which moves each history entry above the new rate up by one place
// through the single history memory, dominates the time per item; the divider runs before it.
// One item is in flight at a time; the next is taken in the cycle after its result transfer.
// After synchronous reset the seed pass writes min(INITIAL_FILL, HISTORY_MAX) entries,
// one per cycle, before the first item is accepted.
`timescale 1ns / 1ps

module trimmed_median_rate_estimator #(
   parameter int HISTORY_MAX  = 1000,
   parameter int INITIAL_FILL = 100,
   parameter int SEED_RATE    = 2880
) (
   input  logic        clock,
   input  logic        reset,
   tmre_req_if.sink    req_chan,
   tmre_rsp_if.source  rsp_chan
);

   localparam int AW   = $clog2(HISTORY_MAX);
   localparam int CW   = $clog2(HISTORY_MAX + 1);
   localparam int FILL = (INITIAL_FILL > HISTORY_MAX) ? HISTORY_MAX : INITIAL_FILL;
   localparam logic [tmre_pkg::RATE_W-1:0] SEED = tmre_pkg::RATE_W'(SEED_RATE);

   tmre_pkg::state_type             state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [AW-1:0]                   base_ff,  base_in;
   logic [CW-1:0]                   pos_ff,   pos_in;
   logic [CW-1:0]                   init_ff,  init_in;
   logic [tmre_pkg::RATE_W-1:0]     rate_ff,  rate_in;

   logic                            accept;
   logic                            div_start;
   tmre_pkg::div_status_type        div_status;
   logic [tmre_pkg::RATE_W-1:0]     div_quotient;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [tmre_pkg::RATE_W-1:0]     wr_data;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [tmre_pkg::RATE_W-1:0]     rd_data;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] i);
      logic [AW+1:0] s;
      s = (AW + 2)'(b) + (AW + 2)'(i);
      if (s >= (AW + 2)'(HISTORY_MAX)) begin
         s = s - (AW + 2)'(HISTORY_MAX);
      end
      return s[AW-1:0];
   endfunction

   assign accept = req_chan.valid && req_chan.ready;

   tmre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (req_chan.elapsed_us),
      .status   (div_status),
      .quotient (div_quotient)
   );

   tmre_store #(
      .DEPTH (HISTORY_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmre_pkg::ST_INIT: begin
            if (init_ff == CW'(FILL - 1)) state_in = tmre_pkg::ST_IDLE;
         end
         tmre_pkg::ST_IDLE: begin
            if (accept) state_in = tmre_pkg::ST_DIV;
         end
         tmre_pkg::ST_DIV: begin
            if (div_status.done) state_in = tmre_pkg::ST_SHIFT_RD;
         end
         tmre_pkg::ST_SHIFT_RD: begin
            state_in = (pos_ff == '0) ? tmre_pkg::ST_PLACE : tmre_pkg::ST_SHIFT_CMP;
         end
         tmre_pkg::ST_SHIFT_CMP: begin
            state_in = (rd_data > rate_ff) ? tmre_pkg::ST_SHIFT_RD : tmre_pkg::ST_PLACE;
         end
         tmre_pkg::ST_PLACE:  state_in = tmre_pkg::ST_MED_RD;
         tmre_pkg::ST_MED_RD: state_in = tmre_pkg::ST_RESP;
         tmre_pkg::ST_RESP: begin
            if (rsp_chan.ready) state_in = tmre_pkg::ST_IDLE;
         end
         default: state_in = tmre_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      base_in        = base_ff;
      pos_in         = pos_ff;
      init_in        = init_ff;
      rate_in        = rate_ff;
      div_start      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = phys(base_ff, pos_ff);
      wr_data        = rate_ff;
      rd_en          = 1'b0;
      rd_addr        = phys(base_ff, pos_ff - CW'(1));
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      unique case (state_ff)
         tmre_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff[AW-1:0];
            wr_data = SEED;
            init_in = init_ff + CW'(1);
         end
         tmre_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               div_start = 1'b1;
               if (count_ff >= CW'(HISTORY_MAX)) begin
                  base_in  = phys(base_ff, CW'(1));
                  count_in = count_ff - CW'(2);
                  pos_in   = count_ff - CW'(2);
               end else begin
                  pos_in = count_ff;
               end
            end
         end
         tmre_pkg::ST_DIV: begin
            if (div_status.done) rate_in = div_quotient;
         end
         tmre_pkg::ST_SHIFT_RD: begin
            rd_en = (pos_ff != '0);
         end
         tmre_pkg::ST_SHIFT_CMP: begin
            if (rd_data > rate_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - CW'(1);
            end
         end
         tmre_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         tmre_pkg::ST_MED_RD: begin
            rd_en   = 1'b1;
            rd_addr = phys(base_ff, count_ff >> 1);
         end
         tmre_pkg::ST_RESP: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmre_pkg::ST_INIT;
         count_ff <= CW'(FILL);
         base_ff  <= '0;
         pos_ff   <= '0;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         base_ff  <= base_in;
         pos_ff   <= pos_in;
         init_ff  <= init_in;
      end
      rate_ff <= rate_in;
   end

   assign rsp_chan.median_rate   = rd_data;
   assign rsp_chan.history_count = tmre_pkg::COUNT_W'(count_ff);

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("Input taken again while an item is in flight.");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> !rsp_chan.valid)
      else $error("More than one result for one item.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_MAX) && {1'b0, base_ff} < (AW + 1)'(HISTORY_MAX))
      else $error("History count or base out of range.");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmre_pkg::ST_IDLE || state_ff == tmre_pkg::ST_RESP) |-> !div_status.busy)
      else $error("Divider busy outside the division step.");
`endif

endmodule
